FILE: hdl/utf8tl_pkg.sv
// Shared types, constants and helper function of the UTF-8 text line layout block.
package utf8tl_pkg;

    // Queue between the decoder and the layout stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_NARROW_WIDTH = 2'd1;
    localparam logic [1:0] CFG_WIDE_WIDTH   = 2'd2;

    localparam logic [15:0] MEASURE_MAX = 16'hFFFF;

    // Glyph classes
    localparam logic [1:0] GLYPH_NARROW = 2'd0;
    localparam logic [1:0] GLYPH_WIDE   = 2'd1;
    localparam logic [1:0] GLYPH_HIDDEN = 2'd2;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00003F;

    typedef struct packed {
        logic              func;
        logic [7:0]        text_byte;
        logic              first_byte;
        logic              last_byte;
        logic signed [11:0] start_x;
    } in_item_t;

    typedef struct packed {
        logic              char_valid;
        logic [20:0]       code_point;
        logic signed [11:0] pos_x;
        logic [1:0]        glyph_kind;
        logic [5:0]        char_advance;
        logic              string_done;
        logic [15:0]       total_advance;
        logic              clipped;
    } out_item_t;

    // One decoded byte handed from the decoder to the layout stage
    typedef struct packed {
        logic              first;
        logic              func;
        logic signed [11:0] start_x;
        logic              have_cp;
        logic [20:0]       cp;
        logic              last;
    } event_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [5:0]  narrow_width;
        logic [5:0]  wide_width;
    } cfg_t;

    function automatic logic wide_range(input logic [20:0] cp);
        return (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
               (cp >= 21'h3000 && cp <= 21'h303F) ||
               (cp >= 21'hFF00 && cp <= 21'hFFEF) ||
               (cp >= 21'h2000 && cp <= 21'h206F) ||
               (cp >= 21'h25A0 && cp <= 21'h26FF) ||
               (cp >= 21'h2190 && cp <= 21'h21FF);
    endfunction

endpackage

FILE: hdl/utf8tl_front.sv
// UTF-8 byte decoder: collects sequences and hands one event per byte to the queue.
module utf8tl_front import utf8tl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_item_t in_item,
    input  logic     in_take,
    output event_t   ev
);

    logic [1:0]  pend_reg, pend_next;
    logic [20:0] accum_reg, accum_next;

    logic [1:0]  pend_e;
    logic [20:0] accum_e;
    logic [7:0]  c;

    always_comb begin
        c       = in_item.text_byte;
        // a new string drops any open sequence before this byte is decoded
        pend_e  = in_item.first_byte ? 2'd0 : pend_reg;
        accum_e = in_item.first_byte ? 21'd0 : accum_reg;

        pend_next  = pend_e;
        accum_next = accum_e;
        ev.first   = in_item.first_byte;
        ev.func    = in_item.func;
        ev.start_x = in_item.start_x;
        ev.last    = in_item.last_byte;
        ev.have_cp = 1'b0;
        ev.cp      = 21'd0;

        if (pend_e == 2'd0) begin
            priority if (c[7] == 1'b0) begin
                ev.cp      = {13'd0, c};
                ev.have_cp = 1'b1;
            end else if (c[7:5] == 3'b110) begin
                accum_next = {16'd0, c[4:0]};
                pend_next  = 2'd1;
            end else if (c[7:4] == 4'b1110) begin
                accum_next = {17'd0, c[3:0]};
                pend_next  = 2'd2;
            end else if (c[7:3] == 5'b11110) begin
                accum_next = {18'd0, c[2:0]};
                pend_next  = 2'd3;
            end else begin
                ev.cp      = CP_REPLACEMENT;
                ev.have_cp = 1'b1;
            end
        end else begin
            accum_next = {accum_e[14:0], c[5:0]};
            pend_next  = pend_e - 2'd1;
            if (pend_e == 2'd1) begin
                ev.cp      = accum_next;
                ev.have_cp = 1'b1;
            end
        end

        // drop a sequence cut short by the end of the string
        if (in_item.last_byte) begin
            pend_next  = 2'd0;
            accum_next = 21'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 2'd0;
            accum_reg <= 21'd0;
        end else if (in_take) begin
            pend_reg  <= pend_next;
            accum_reg <= accum_next;
        end
    end

endmodule

FILE: hdl/utf8tl_queue.sv
// Short event queue between the decoder and the layout stage.
module utf8tl_queue import utf8tl_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output event_t head
);

    event_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hdl/utf8tl_back.sv
// Layout stage: classifies code points, advances the cursor, clips and drives the result register.
module utf8tl_back import utf8tl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  event_t    ev,
    input  logic      ev_valid,
    output logic      ev_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [16:0]       cursor_reg, cursor_next;
    logic signed [11:0] origin_reg, origin_next;
    logic              stopped_reg, stopped_next;
    logic              mode_reg, mode_next;
    logic              out_valid_reg;
    out_item_t         out_reg, res;

    logic [16:0]  cursor_e;
    logic         wide, placed;
    logic [5:0]   adv;
    logic [17:0]  meas_sum;
    logic signed [17:0] lay_sum, diff;

    assign ev_pop  = ev_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        // a new string reloads the cursor state before this byte is used
        mode_next    = ev.first ? ev.func : mode_reg;
        origin_next  = ev.first ? ev.start_x : origin_reg;
        stopped_next = ev.first ? 1'b0 : stopped_reg;
        if (ev.first) begin
            cursor_e = ev.func ? 17'd0 : {{5{ev.start_x[11]}}, ev.start_x};
        end else begin
            cursor_e = cursor_reg;
        end
        cursor_next = cursor_e;

        wide     = wide_range(ev.cp);
        adv      = wide ? cfg.wide_width : cfg.narrow_width;
        meas_sum = {1'b0, cursor_e} + {12'd0, adv};
        lay_sum  = $signed({cursor_e[16], cursor_e}) + $signed({12'd0, adv});
        placed   = 1'b0;

        if (ev.have_cp) begin
            if (mode_next) begin
                cursor_next = (meas_sum > {2'b00, MEASURE_MAX}) ? {1'b0, MEASURE_MAX}
                                                                 : meas_sum[16:0];
            end else if (!stopped_next) begin
                if (lay_sum > $signed({7'd0, cfg.frame_width})) begin
                    stopped_next = 1'b1;
                end else begin
                    placed      = 1'b1;
                    cursor_next = lay_sum[16:0];
                end
            end
        end

        diff = $signed({cursor_next[16], cursor_next})
             - $signed({{6{origin_next[11]}}, origin_next});

        res = '0;
        if (placed) begin
            res.char_valid   = 1'b1;
            res.code_point   = ev.cp;
            res.pos_x        = cursor_e[11:0];
            res.char_advance = adv;
            if (wide) begin
                res.glyph_kind = GLYPH_WIDE;
            end else if (ev.cp >= 21'h20 && ev.cp < 21'h7F) begin
                res.glyph_kind = GLYPH_NARROW;
            end else begin
                res.glyph_kind = GLYPH_HIDDEN;
            end
        end
        if (ev.last) begin
            res.string_done = 1'b1;
            if (mode_next) begin
                res.total_advance = cursor_next[15:0];
            end else if (diff < 0) begin
                res.total_advance = 16'd0;
            end else if (diff > $signed({2'b00, MEASURE_MAX})) begin
                res.total_advance = MEASURE_MAX;
            end else begin
                res.total_advance = diff[15:0];
            end
            res.clipped = !mode_next && stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg    <= 17'd0;
            origin_reg    <= 12'sd0;
            stopped_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ev_pop) begin
                cursor_reg    <= cursor_next;
                origin_reg    <= origin_next;
                stopped_reg   <= stopped_next;
                mode_reg      <= mode_next;
                out_valid_reg <= placed || ev.last;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (ev_pop && (placed || ev.last)) begin
            out_reg <= res;
        end
    end

endmodule

FILE: hdl/utf8_text_line_layout.sv
// Top level of the UTF-8 text line layout block: configuration registers and the two stages.
//
// The block takes one UTF-8 byte per cycle while s_ready is high and returns at most one result per
// byte: a placed character, the closing result of a string, or both in one. A byte is decoded in
// the cycle it is accepted and written into a four-entry event queue; the layout stage takes one
// event per cycle from the queue into the result register while it is free or m_ready is high, and
// the sustained rate is one byte per clock while m_ready stays high. When the result side stalls,
// the queue absorbs up to four bytes before s_ready falls. Configuration writes take effect at the
// next clock edge and are meant for times when no string is in flight.
module utf8_text_line_layout import utf8tl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata
);

    cfg_t   cfg_reg;
    event_t front_ev, head_ev;
    logic   q_full, q_empty, q_pop, s_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= 11'd240;
            cfg_reg.narrow_width <= 6'd8;
            cfg_reg.wide_width   <= 6'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata;
                CFG_NARROW_WIDTH: cfg_reg.narrow_width <= cfg_wdata[5:0];
                CFG_WIDE_WIDTH:   cfg_reg.wide_width   <= cfg_wdata[5:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign s_take  = s_valid && !q_full;

    utf8tl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (s_data),
        .in_take (s_take),
        .ev      (front_ev)
    );

    utf8tl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_take),
        .push_data (front_ev),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head_ev)
    );

    utf8tl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ev       (head_ev),
        .ev_valid (!q_empty),
        .ev_pop   (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
